FILE: sv/ttxattr_pkg.sv
`timescale 1ns / 1ps

package ttxattr_pkg;

    // Field widths
    localparam int OP_W          = 2;
    localparam int CODE_W        = 8;
    localparam int COLOUR_W      = 3;
    localparam int CELL_COLOUR_W = 6;
    localparam int GLYPH_W       = 9;
    localparam int FLAGS_W       = 7;
    localparam int FRAME_W       = 6;
    localparam int CFG_DATA_W    = 6;
    localparam int CFG_INDEX_W   = 1;

    // Stream widths
    localparam int IN_TDATA_W    = 8;
    localparam int IN_TUSER_W    = 2;
    localparam int OUT_TDATA_W   = 24;

    typedef enum logic [OP_W-1:0] {
        OP_CHAR      = 2'd0,
        OP_ROW_END   = 2'd1,
        OP_FRAME_END = 2'd2
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FLASH_HIDE   = 1'b0,
        CFG_FLASH_PERIOD = 1'b1
    } cfg_index_t;

    // Attribute flag bit positions
    localparam int AF_DBL   = 0;
    localparam int AF_SEP   = 1;
    localparam int AF_FLASH = 2;
    localparam int AF_BOX   = 3;
    localparam int AF_GRAPH = 4;
    localparam int AF_CONC  = 5;
    localparam int AF_HOLD  = 6;

    // Control codes
    localparam logic [CODE_W-1:0] CC_NUL       = 8'h00;
    localparam logic [CODE_W-1:0] CC_FLASH     = 8'h08;
    localparam logic [CODE_W-1:0] CC_STEADY    = 8'h09;
    localparam logic [CODE_W-1:0] CC_BOX_ON    = 8'h0a;
    localparam logic [CODE_W-1:0] CC_BOX_OFF   = 8'h0b;
    localparam logic [CODE_W-1:0] CC_NORMAL_HT = 8'h0c;
    localparam logic [CODE_W-1:0] CC_DOUBLE_HT = 8'h0d;
    localparam logic [CODE_W-1:0] CC_CONCEAL   = 8'h18;
    localparam logic [CODE_W-1:0] CC_SEP_ON    = 8'h19;
    localparam logic [CODE_W-1:0] CC_SEP_OFF   = 8'h1a;
    localparam logic [CODE_W-1:0] CC_BLACK_BG  = 8'h1c;
    localparam logic [CODE_W-1:0] CC_NEW_BG    = 8'h1d;
    localparam logic [CODE_W-1:0] CC_HOLD_ON   = 8'h1e;
    localparam logic [CODE_W-1:0] CC_HOLD_OFF  = 8'h1f;

    // Upper five bits of the alpha and graphics colour code groups
    localparam logic [4:0] CC_ALPHA_GROUP   = 5'b00000;
    localparam logic [4:0] CC_GRAPHIC_GROUP = 5'b00010;

    localparam logic [CODE_W-1:0]  CODE_SPACE  = 8'h20;
    localparam logic [CODE_W-1:0]  CTRL_LIMIT  = 8'h20;
    localparam logic [GLYPH_W-1:0] GLYPH_SPACE = 9'd32;
    localparam logic [GLYPH_W-1:0] MOSAIC_OFS_UPPER = 9'd64;
    localparam logic [GLYPH_W-1:0] MOSAIC_OFS_LOWER = 9'd96;
    localparam logic [GLYPH_W-1:0] MOSAIC_OFS_SEP   = 9'd64;

    localparam logic [COLOUR_W-1:0] COLOUR_BLACK = 3'd0;
    localparam logic [COLOUR_W-1:0] COLOUR_WHITE = 3'd7;

    localparam logic [CFG_DATA_W-1:0] RESET_FLASH_HIDE   = 6'd38;
    localparam logic [CFG_DATA_W-1:0] RESET_FLASH_PERIOD = 6'd50;

    typedef struct packed {
        logic [FLAGS_W-1:0]  flags;
        logic [COLOUR_W-1:0] fore;
        logic [COLOUR_W-1:0] back;
        logic [COLOUR_W-1:0] prev;
        logic [CODE_W-1:0]   held;
    } row_state_t;

    localparam row_state_t ROW_RESET = '{
        flags: '0,
        fore:  COLOUR_WHITE,
        back:  COLOUR_BLACK,
        prev:  COLOUR_WHITE,
        held:  CODE_SPACE
    };

    typedef struct packed {
        logic [CFG_DATA_W-1:0] hide_after;
        logic [CFG_DATA_W-1:0] period_last;
    } flash_cfg_t;

    typedef struct packed {
        logic                     skip;
        logic                     dbl;
        logic                     draw;
        logic [CELL_COLOUR_W-1:0] colour;
        logic [GLYPH_W-1:0]       glyph;
    } result_t;

endpackage

FILE: sv/ttxattr_decode.sv
`timescale 1ns / 1ps

module ttxattr_decode (
    input  logic [ttxattr_pkg::OP_W-1:0]    op,
    input  logic [ttxattr_pkg::CODE_W-1:0]  code,
    input  ttxattr_pkg::row_state_t         row,
    input  logic [ttxattr_pkg::FRAME_W-1:0] flash_cnt,
    input  ttxattr_pkg::flash_cfg_t         cfg,
    output ttxattr_pkg::row_state_t         row_next,
    output logic [ttxattr_pkg::FRAME_W-1:0] frame_next,
    output ttxattr_pkg::result_t            res,
    output logic                            res_valid
);

    ttxattr_pkg::row_state_t             ctl;
    ttxattr_pkg::row_state_t             char_next;
    logic [ttxattr_pkg::CODE_W-1:0]      shown;
    logic [ttxattr_pkg::GLYPH_W-1:0]     glyph;
    logic [ttxattr_pkg::CELL_COLOUR_W-1:0] colour;
    logic [ttxattr_pkg::FRAME_W:0]       frame_inc;
    logic                                is_ctrl;
    logic                                blank;
    logic                                hidden;
    logic                                mosaic;

    // Control code effect; printable codes fall through every branch unchanged
    always_comb begin
        ctl = row;
        if (code[7:3] == ttxattr_pkg::CC_ALPHA_GROUP && code[2:0] != 3'd0) begin
            ctl.fore = code[2:0];
            ctl.prev = code[2:0];
            ctl.flags[ttxattr_pkg::AF_GRAPH] = 1'b0;
            ctl.flags[ttxattr_pkg::AF_CONC]  = 1'b0;
        end else if (code[7:3] == ttxattr_pkg::CC_GRAPHIC_GROUP && code[2:0] != 3'd0) begin
            ctl.fore = code[2:0];
            ctl.prev = code[2:0];
            ctl.flags[ttxattr_pkg::AF_GRAPH] = 1'b1;
            ctl.flags[ttxattr_pkg::AF_CONC]  = 1'b0;
        end else begin
            case (code)
                ttxattr_pkg::CC_FLASH:     ctl.flags[ttxattr_pkg::AF_FLASH] = 1'b1;
                ttxattr_pkg::CC_STEADY:    ctl.flags[ttxattr_pkg::AF_FLASH] = 1'b0;
                ttxattr_pkg::CC_BOX_ON:    ctl.flags[ttxattr_pkg::AF_BOX]   = 1'b1;
                ttxattr_pkg::CC_BOX_OFF:   ctl.flags[ttxattr_pkg::AF_BOX]   = 1'b0;
                ttxattr_pkg::CC_NORMAL_HT: ctl.flags[ttxattr_pkg::AF_DBL]   = 1'b0;
                ttxattr_pkg::CC_DOUBLE_HT: ctl.flags[ttxattr_pkg::AF_DBL]   = 1'b1;
                ttxattr_pkg::CC_CONCEAL:   ctl.flags[ttxattr_pkg::AF_CONC]  = 1'b1;
                ttxattr_pkg::CC_SEP_ON:    ctl.flags[ttxattr_pkg::AF_SEP]   = 1'b1;
                ttxattr_pkg::CC_SEP_OFF:   ctl.flags[ttxattr_pkg::AF_SEP]   = 1'b0;
                ttxattr_pkg::CC_BLACK_BG:  ctl.back = ttxattr_pkg::COLOUR_BLACK;
                ttxattr_pkg::CC_NEW_BG:    ctl.back = row.prev;
                ttxattr_pkg::CC_HOLD_ON:   ctl.flags[ttxattr_pkg::AF_HOLD]  = 1'b1;
                ttxattr_pkg::CC_HOLD_OFF:  ctl.flags[ttxattr_pkg::AF_HOLD]  = 1'b0;
                default: ;
            endcase
        end
    end

    // Shown code, colour and glyph of a character cell
    always_comb begin
        is_ctrl = (code < ttxattr_pkg::CTRL_LIMIT);
        blank   = (code == ttxattr_pkg::CC_NUL);
        if (is_ctrl) begin
            shown = ctl.flags[ttxattr_pkg::AF_HOLD] ? row.held : ttxattr_pkg::CODE_SPACE;
        end else begin
            shown = code;
        end

        colour = shown[7] ? {ctl.fore, ctl.back} : {ctl.back, ctl.fore};

        hidden = ctl.flags[ttxattr_pkg::AF_CONC]
              || (ctl.flags[ttxattr_pkg::AF_FLASH] && flash_cnt > cfg.hide_after);
        mosaic = ctl.flags[ttxattr_pkg::AF_GRAPH] && shown[5];

        char_next = ctl;
        if (hidden) begin
            glyph = ttxattr_pkg::GLYPH_SPACE;
        end else begin
            char_next.held = shown;
            glyph = {1'b0, shown};
            if (mosaic) begin
                glyph = glyph
                      + (shown[6] ? ttxattr_pkg::MOSAIC_OFS_UPPER
                                  : ttxattr_pkg::MOSAIC_OFS_LOWER)
                      + (ctl.flags[ttxattr_pkg::AF_SEP] ? ttxattr_pkg::MOSAIC_OFS_SEP
                                                       : '0);
            end
        end

        frame_inc = {1'b0, flash_cnt} + 7'd1;
    end

    // Select the effect of the item kind
    always_comb begin
        row_next   = row;
        frame_next = flash_cnt;
        res        = '0;
        res_valid  = 1'b0;
        case (ttxattr_pkg::op_t'(op))
            ttxattr_pkg::OP_CHAR: begin
                row_next   = char_next;
                res.glyph  = glyph;
                res.colour = colour;
                res.draw   = !blank || ctl.flags[ttxattr_pkg::AF_HOLD];
                res.dbl    = ctl.flags[ttxattr_pkg::AF_DBL];
                res.skip   = 1'b0;
                res_valid  = 1'b1;
            end
            ttxattr_pkg::OP_ROW_END: begin
                row_next   = ttxattr_pkg::ROW_RESET;
                res.glyph  = ttxattr_pkg::GLYPH_SPACE;
                res.skip   = row.flags[ttxattr_pkg::AF_DBL];
                res_valid  = 1'b1;
            end
            ttxattr_pkg::OP_FRAME_END: begin
                if (frame_inc > {1'b0, cfg.period_last} || frame_inc[ttxattr_pkg::FRAME_W]) begin
                    frame_next = '0;
                end else begin
                    frame_next = frame_inc[ttxattr_pkg::FRAME_W-1:0];
                end
            end
            default: ;
        endcase
    end

endmodule

FILE: sv/teletext_serial_attribute_decoder.sv
`timescale 1ns / 1ps

// Teletext serial attribute decoder.
// Input stream (s_*): one transfer per item. s_tuser carries the item kind
// (character, end of row, end of frame), s_tdata the character byte.
// Output stream (m_*): one transfer per character or end of row, carrying
// glyph index, packed colour, draw flag, double-height flag and the
// skip-next-row flag. End of frame only advances the flash counter.
// Configuration (cfg_*): index 0 sets the flash hide threshold, index 1 the
// last value of the flash frame counter; write only while the block is idle.
// Each item is registered in the input register, and its result in the
// output register that drives m_tvalid.
// Throughput: one item per cycle while the receiver keeps up; row attributes
// update in the same cycle that decodes them, so items chain without bubbles.
// Reset (aresetn low, synchronous): both stages empty, row attributes to white
// on black with no flags, held character space, frame counter zero, registers
// to their defaults.
// When the receiver stalls, the result holds in the output register, the
// next item waits in the input register, and s_tready drops only when both
// are occupied.

module teletext_serial_attribute_decoder (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // s_tdata: [7:0] char_byte
    input  logic [ttxattr_pkg::IN_TDATA_W-1:0]   s_tdata,
    // s_tuser: [1:0] op
    input  logic [ttxattr_pkg::IN_TUSER_W-1:0]   s_tuser,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // m_tdata: [8:0] glyph_index, [14:9] cell_colour, [15] draw_cell,
    //          [16] double_height, [17] skip_next_row, [23:18] zero
    output logic [ttxattr_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ttxattr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ttxattr_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // Input stage
    logic                                 in_valid_reg;
    logic [ttxattr_pkg::OP_W-1:0]         in_op_reg;
    logic [ttxattr_pkg::CODE_W-1:0]       in_code_reg;

    // Output stage
    logic                                 out_valid_reg;
    ttxattr_pkg::result_t                 out_res_reg;

    // Attribute state and configuration
    ttxattr_pkg::row_state_t              row_reg;
    ttxattr_pkg::row_state_t              row_next;
    logic [ttxattr_pkg::FRAME_W-1:0]      frame_reg;
    logic [ttxattr_pkg::FRAME_W-1:0]      frame_next;
    ttxattr_pkg::flash_cfg_t              cfg_reg;

    ttxattr_pkg::result_t                 res;
    logic                                 res_valid;
    logic                                 advance;
    logic                                 s_xfer;

    ttxattr_decode u_decode (
        .op          (in_op_reg),
        .code        (in_code_reg),
        .row         (row_reg),
        .flash_cnt   (frame_reg),
        .cfg         (cfg_reg),
        .row_next    (row_next),
        .frame_next  (frame_next),
        .res         (res),
        .res_valid   (res_valid)
    );

    // Retire the held item when its result has a slot, or when it makes none
    assign advance   = in_valid_reg && (!res_valid || !out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_xfer    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Input register: load on every transfer, drain on advance
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_op_reg   <= s_tuser[ttxattr_pkg::OP_W-1:0];
            in_code_reg <= s_tdata[ttxattr_pkg::CODE_W-1:0];
        end
    end

    // Output register: hold while the receiver stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            out_res_reg <= res;
        end
    end

    // Advance attribute state once per retired item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg   <= ttxattr_pkg::ROW_RESET;
            frame_reg <= '0;
        end else if (advance) begin
            row_reg   <= row_next;
            frame_reg <= frame_next;
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hide_after  <= ttxattr_pkg::RESET_FLASH_HIDE;
            cfg_reg.period_last <= ttxattr_pkg::RESET_FLASH_PERIOD;
        end else if (cfg_valid && cfg_ready) begin
            case (ttxattr_pkg::cfg_index_t'(cfg_index))
                ttxattr_pkg::CFG_FLASH_HIDE:   cfg_reg.hide_after  <= cfg_data;
                ttxattr_pkg::CFG_FLASH_PERIOD: cfg_reg.period_last <= cfg_data;
                default: ;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_res_reg.skip, out_res_reg.dbl, out_res_reg.draw,
                       out_res_reg.colour, out_res_reg.glyph};

endmodule

FILE: sv/ttxattr_checker.sv
`timescale 1ns / 1ps

module ttxattr_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic [ttxattr_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                                m_tvalid,
    input logic                                m_tready
);

    // Reset empties the output stage
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // Stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Padding bits stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[23:18] == 6'd0)
        else $error("padding bits set");

    // A skip-flagged (row-end) result is a bare space with no colour, draw or height
    a_row_end_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[17] |-> m_tdata[16:0] == 17'h00020)
        else $error("skip flag on a character result");

    // An undrawn cell shows a space, plain or as a (separated) mosaic space
    a_blank_space: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[15] |->
            (m_tdata[8:0] == 9'd32 || m_tdata[8:0] == 9'd128 || m_tdata[8:0] == 9'd192))
        else $error("undrawn cell with non-space glyph");

endmodule

bind teletext_serial_attribute_decoder ttxattr_checker u_ttxattr_checker (.*);

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ttxattr_pkg::*;

    localparam int          CYCLE_LIMIT     = 200000;
    localparam int          RESET_CYCLES    = 8;
    localparam int          DRAIN_CYCLES    = 6;
    localparam int          HOLD_CYCLES     = 300;
    localparam int          NUM_PHASES      = 6;
    localparam int          ITEMS_PER_PHASE = 125;
    localparam int          MAX_REPORTS     = 10;
    // op value outside the enum; the block must drop it
    localparam logic [1:0]  OP_IGNORED      = 2'd3;

    // Flash settings per random phase; phase 4 draws its own pair
    localparam logic [5:0] HIDE_SET   [NUM_PHASES] = '{6'd0, 6'd63, 6'd5, 6'd20, 6'd0, 6'd38};
    localparam logic [5:0] PERIOD_SET [NUM_PHASES] = '{6'd1, 6'd63, 6'd0, 6'd63, 6'd1, 6'd50};

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [CODE_W-1:0] chr;
        bit                typed;
        result_t           exp_res;
    } stim_t;

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic [IN_TDATA_W-1:0]      s_tdata;
    logic [IN_TUSER_W-1:0]      s_tuser;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [OUT_TDATA_W-1:0]     m_tdata;
    logic                       m_tvalid;
    logic                       m_tready;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_INDEX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;

    // Row attributes and flash state tracked alongside the block
    logic [FLAGS_W-1:0]    row_flags;
    logic [COLOUR_W-1:0]   fg_colour;
    logic [COLOUR_W-1:0]   bg_colour;
    logic [COLOUR_W-1:0]   prev_colour;
    logic [CODE_W-1:0]     held_code;
    logic [FRAME_W-1:0]    frame_cnt;
    logic [CFG_DATA_W-1:0] hide_after;
    logic [CFG_DATA_W-1:0] period_last;

    result_t     cells_due [$];
    stim_t       directed [$];
    int unsigned fail_count;
    int unsigned items_sent;
    int unsigned cells_checked;
    int unsigned cycle_cnt;
    bit          src_gaps;
    bit          snk_gaps;
    bit          hold_req;

    teletext_serial_attribute_decoder uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Idle length: mostly none, often short, now and then long
    function automatic int unsigned idle_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        else if (roll < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic void clear_row();
        row_flags   = '0;
        fg_colour   = COLOUR_WHITE;
        bg_colour   = COLOUR_BLACK;
        prev_colour = COLOUR_WHITE;
        held_code   = CODE_SPACE;
    endfunction

    // Serial attribute update for a control code
    function automatic void take_control(input logic [CODE_W-1:0] code);
        if (code[7:3] == CC_ALPHA_GROUP && code[2:0] != 3'd0) begin
            fg_colour           = code[2:0];
            prev_colour         = code[2:0];
            row_flags[AF_GRAPH] = 1'b0;
            row_flags[AF_CONC]  = 1'b0;
        end else if (code[7:3] == CC_GRAPHIC_GROUP && code[2:0] != 3'd0) begin
            fg_colour           = code[2:0];
            prev_colour         = code[2:0];
            row_flags[AF_CONC]  = 1'b0;
            row_flags[AF_GRAPH] = 1'b1;
        end else begin
            case (code)
                CC_FLASH:     row_flags[AF_FLASH] = 1'b1;
                CC_STEADY:    row_flags[AF_FLASH] = 1'b0;
                CC_BOX_ON:    row_flags[AF_BOX]   = 1'b1;
                CC_BOX_OFF:   row_flags[AF_BOX]   = 1'b0;
                CC_NORMAL_HT: row_flags[AF_DBL]   = 1'b0;
                CC_DOUBLE_HT: row_flags[AF_DBL]   = 1'b1;
                CC_CONCEAL:   row_flags[AF_CONC]  = 1'b1;
                CC_SEP_ON:    row_flags[AF_SEP]   = 1'b1;
                CC_SEP_OFF:   row_flags[AF_SEP]   = 1'b0;
                CC_BLACK_BG:  bg_colour = COLOUR_BLACK;
                CC_NEW_BG:    bg_colour = prev_colour;
                CC_HOLD_ON:   row_flags[AF_HOLD]  = 1'b1;
                CC_HOLD_OFF:  row_flags[AF_HOLD]  = 1'b0;
                default: ;
            endcase
        end
    endfunction

    // Decode one accepted item; returns 1 when it yields a cell result
    function automatic bit decode_cell(input logic [OP_W-1:0] op,
                                       input logic [CODE_W-1:0] chr,
                                       output result_t res_out);
        logic [CODE_W-1:0]  code;
        logic [GLYPH_W-1:0] glyph;
        logic               blank;
        logic [FRAME_W:0]   bumped;
        res_out = '0;
        if (op == OP_CHAR) begin
            code  = chr;
            blank = 1'b0;
            if (code < CTRL_LIMIT) begin
                if (code == CC_NUL)
                    blank = 1'b1;
                else
                    take_control(code);
                code = row_flags[AF_HOLD] ? held_code : CODE_SPACE;
            end
            res_out.colour = code[7] ? {fg_colour, bg_colour} : {bg_colour, fg_colour};
            glyph = {1'b0, code};
            if (row_flags[AF_CONC]) begin
                glyph = GLYPH_SPACE;
            end else if (row_flags[AF_FLASH] && frame_cnt > hide_after) begin
                glyph = GLYPH_SPACE;
            end else begin
                held_code = code;
                if (row_flags[AF_GRAPH] && code[5]) begin
                    glyph += code[6] ? MOSAIC_OFS_UPPER : MOSAIC_OFS_LOWER;
                    if (row_flags[AF_SEP])
                        glyph += MOSAIC_OFS_SEP;
                end
            end
            res_out.glyph = glyph;
            res_out.draw  = !blank || row_flags[AF_HOLD];
            res_out.dbl   = row_flags[AF_DBL];
            return 1'b1;
        end else if (op == OP_ROW_END) begin
            res_out.glyph = GLYPH_SPACE;
            res_out.skip  = row_flags[AF_DBL];
            clear_row();
            return 1'b1;
        end else if (op == OP_FRAME_END) begin
            bumped = {1'b0, frame_cnt} + 1'b1;
            if (bumped > {1'b0, period_last} || bumped > 7'd63)
                frame_cnt = '0;
            else
                frame_cnt = bumped[FRAME_W-1:0];
        end
        return 1'b0;
    endfunction

    function automatic stim_t drow(input logic [OP_W-1:0] op, input logic [CODE_W-1:0] chr,
                                   input bit typed, input int glyph, input int colour,
                                   input bit draw);
        stim_t r;
        r.op             = op;
        r.chr            = chr;
        r.typed          = typed;
        r.exp_res        = '0;
        r.exp_res.glyph  = glyph[GLYPH_W-1:0];
        r.exp_res.colour = colour[CELL_COLOUR_W-1:0];
        r.exp_res.draw   = draw;
        return r;
    endfunction

    function automatic void note_failure(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] %s", $realtime, what);
    endfunction

    // Offer one item; predict its result once the transfer has happened
    task automatic transfer_item(input logic [OP_W-1:0] op, input logic [CODE_W-1:0] chr,
                                 input bit typed, input result_t typed_res);
        result_t     pred;
        int unsigned gap;
        gap = src_gaps ? idle_len() : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= chr;
        do @(posedge aclk); while (!s_tready);
        if (decode_cell(op, chr, pred))
            cells_due.push_back(typed ? typed_res : pred);
        if (op != OP_IGNORED)
            items_sent++;
    endtask

    // Write both flash registers back to back, valid held between the two
    task automatic write_flash(input logic [5:0] hide, input logic [5:0] period);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_FLASH_HIDE;
        cfg_data  <= hide;
        do @(posedge aclk); while (!cfg_ready);
        hide_after = hide;
        cfg_index <= CFG_FLASH_PERIOD;
        cfg_data  <= period;
        do @(posedge aclk); while (!cfg_ready);
        period_last = period;
        cfg_valid <= 1'b0;
    endtask

    // Drop valid, wait for every result, then cover the pipeline depth
    task automatic drain();
        s_tvalid <= 1'b0;
        while (cells_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Receiver: random back-pressure, plus one long hold on request
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_left == 0) begin
                if (hold_req) begin
                    hold_req   = 1'b0;
                    stall_left = HOLD_CYCLES;
                end else if (snk_gaps) begin
                    stall_left = idle_len();
                end
            end
            if (stall_left != 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compare each result transfer with the oldest predicted cell
    always @(posedge aclk) begin
        result_t want;
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[$bits(result_t)-1:0]);
            if (cells_due.size() == 0) begin
                note_failure($sformatf("unexpected result tdata=%h", m_tdata));
            end else begin
                want = cells_due.pop_front();
                cells_checked++;
                if (got.glyph != want.glyph || got.colour != want.colour ||
                    got.draw != want.draw || got.dbl != want.dbl ||
                    got.skip != want.skip ||
                    m_tdata[OUT_TDATA_W-1:$bits(result_t)] != '0)
                    note_failure($sformatf({"mismatch: exp glyph=%0d colour=%0d draw=%0d ",
                        "dbl=%0d skip=%0d, got glyph=%0d colour=%0d draw=%0d dbl=%0d ",
                        "skip=%0d pad=%h"}, want.glyph, want.colour, want.draw, want.dbl,
                        want.skip, got.glyph, got.colour, got.draw, got.dbl, got.skip,
                        m_tdata[OUT_TDATA_W-1:$bits(result_t)]));
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, cells_due.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        logic [5:0]  hide;
        logic [5:0]  period;
        logic [1:0]  op;
        int unsigned sent;
        int unsigned row_len;
        int unsigned roll;
        bit          pressed;

        fail_count    = 0;
        items_sent    = 0;
        cells_checked = 0;
        cycle_cnt     = 0;
        hold_req      = 1'b0;
        pressed       = 1'b0;
        src_gaps      = 1'b1;
        snk_gaps      = 1'b1;
        hide_after    = RESET_FLASH_HIDE;
        period_last   = RESET_FLASH_PERIOD;
        frame_cnt     = '0;
        clear_row();

        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= '0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_FLASH_HIDE;
        cfg_data  <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows; typed results are the plain cases after reset
        directed.push_back(drow(OP_CHAR,      8'h41,        1, 65,  7,  1));
        directed.push_back(drow(OP_CHAR,      CC_NUL,       1, 32,  7,  0));
        directed.push_back(drow(OP_CHAR,      8'hff,        1, 255, 56, 1));
        directed.push_back(drow(OP_CHAR,      8'h80,        1, 128, 56, 1));
        directed.push_back(drow(OP_ROW_END,   8'h00,        1, 32,  0,  0));
        directed.push_back(drow(OP_CHAR,      8'h11,        0, 0,   0,  0));
        directed.push_back(drow(OP_CHAR,      8'h20,        0, 0,   0,  0));
        directed.push_back(drow(OP_CHAR,      8'h7f,        0, 0,   0,  0));
        directed.push_back(drow(OP_CHAR,      CC_SEP_ON,    0, 0,   0,  0));
        directed.push_back(drow(OP_CHAR,      8'hff,        0, 0,   0,  0));
        directed.push_back(drow(OP_CHAR,      CC_HOLD_ON,   0, 0,   0,  0));
        directed.push_back(drow(OP_CHAR,      CC_NUL,       0, 0,   0,  0));
        directed.push_back(drow(OP_CHAR,      CC_DOUBLE_HT, 0, 0,   0,  0));
        directed.push_back(drow(OP_CHAR,      CC_NEW_BG,    0, 0,   0,  0));
        directed.push_back(drow(OP_CHAR,      CC_FLASH,     0, 0,   0,  0));
        directed.push_back(drow(OP_CHAR,      CC_BOX_ON,    0, 0,   0,  0));
        directed.push_back(drow(OP_CHAR,      CC_CONCEAL,   0, 0,   0,  0));
        directed.push_back(drow(OP_CHAR,      8'h41,        0, 0,   0,  0));
        directed.push_back(drow(OP_CHAR,      8'h0e,        0, 0,   0,  0));
        directed.push_back(drow(OP_IGNORED,   8'ha5,        0, 0,   0,  0));
        directed.push_back(drow(OP_FRAME_END, 8'h5a,        0, 0,   0,  0));
        directed.push_back(drow(OP_ROW_END,   8'hff,        0, 0,   0,  0));
        directed.push_back(drow(OP_CHAR,      CC_BLACK_BG,  0, 0,   0,  0));
        directed.push_back(drow(OP_CHAR,      8'h17,        0, 0,   0,  0));
        directed.push_back(drow(OP_ROW_END,   8'h00,        0, 0,   0,  0));

        foreach (directed[i])
            transfer_item(directed[i].op, directed[i].chr, directed[i].typed,
                          directed[i].exp_res);
        drain();

        // Random phases: mostly well-formed rows of text and control codes,
        // some frame ends, unterminated rows and raw noise
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            hide   = (ph == 4) ? 6'($urandom_range(0, 63)) : HIDE_SET[ph];
            period = (ph == 4) ? 6'($urandom_range(1, 63)) : PERIOD_SET[ph];
            write_flash(hide, period);
            // keep the first phase free of idling on both sides
            src_gaps = (ph != 0) && ($urandom_range(0, 3) != 0);
            snk_gaps = (ph != 0) && ($urandom_range(0, 3) != 0);
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 9) == 0) begin
                    op = 2'($urandom_range(0, 3));
                    transfer_item(op, 8'($urandom), 0, '0);
                    if (op != OP_IGNORED)
                        sent++;
                end else begin
                    row_len = $urandom_range(1, 40);
                    for (int k = 0; k < row_len; k++) begin
                        roll = $urandom_range(0, 99);
                        if (roll < 12) begin
                            transfer_item(OP_FRAME_END, 8'($urandom), 0, '0);
                            sent++;
                        end else if (roll < 14) begin
                            transfer_item(OP_IGNORED, 8'($urandom), 0, '0);
                        end
                        if ($urandom_range(0, 99) < 35)
                            transfer_item(OP_CHAR, 8'($urandom_range(0, 31)), 0, '0);
                        else
                            transfer_item(OP_CHAR, 8'($urandom_range(32, 255)), 0, '0);
                        sent++;
                        // hold the receiver off while the sender keeps offering
                        if (ph == 1 && !pressed && sent >= 30) begin
                            pressed  = 1'b1;
                            src_gaps = 1'b0;
                            hold_req = 1'b1;
                        end
                    end
                    if ($urandom_range(0, 9) != 0) begin
                        transfer_item(OP_ROW_END, 8'($urandom), 0, '0);
                        sent++;
                    end
                end
            end
            drain();
        end

        $display("Run covered %0d items and %0d checked results across %0d flash settings,",
                 items_sent, cells_checked, NUM_PHASES + 1);
        $display("with random idling, a %0d-cycle output hold and dropped op codes.",
                 HOLD_CYCLES);
        if (fail_count == 0 && cells_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d failures", fail_count);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: teletext_serial_attribute_decoder.f
sv/ttxattr_pkg.sv
sv/ttxattr_decode.sv
sv/teletext_serial_attribute_decoder.sv
sv/ttxattr_checker.sv
sim/testbench.sv
